// ----- rtl/pats_pkg.sv -----
// shared types, codes and constants for the priority aging task scheduler
// no dependencies
package pats_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int LEN_W     = SLOT_W + 1;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_CREATE = 3'd1;
    localparam logic [2:0] MODE_SETP   = 3'd2;
    localparam logic [2:0] MODE_GETP   = 3'd3;
    localparam logic [2:0] MODE_YIELD  = 3'd4;
    localparam logic [2:0] MODE_PICK   = 3'd5;
    localparam logic [2:0] MODE_EXIT   = 3'd6;
    localparam logic [2:0] MODE_JOIN   = 3'd7;

    localparam logic [2:0] RES_OK      = 3'd0;
    localparam logic [2:0] RES_REJECT  = 3'd1;
    localparam logic [2:0] RES_NONE    = 3'd2;
    localparam logic [2:0] RES_SUSPEND = 3'd3;
    localparam logic [2:0] RES_FULL    = 3'd4;

    localparam logic [2:0] ST_FREE       = 3'd0;
    localparam logic [2:0] ST_READY      = 3'd1;
    localparam logic [2:0] ST_RUNNING    = 3'd2;
    localparam logic [2:0] ST_SUSPENDED  = 3'd3;
    localparam logic [2:0] ST_TERMINATED = 3'd4;

    localparam logic signed [5:0] PRIO_MAX  = 6'sd20;
    localparam logic signed [5:0] PRIO_MIN  = -6'sd20;
    localparam logic signed [6:0] AGE_FLOOR = -7'sd64;
    localparam logic [7:0] QUANTUM_RST = 8'd20;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SIMPLE, OP_PSCAN, OP_FIND, OP_SHIFT, OP_DROP,
        OP_WAKE, OP_PFIN, OP_XFIN, OP_JFIN, OP_PUBLISH
    } t_op;

    typedef enum logic [1:0] {
        PATH_SIMPLE, PATH_PICK, PATH_EXIT, PATH_JOIN
    } t_path;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        t_path             path;
        logic [LEN_W-1:0]  len;
        logic              match;
        logic [SLOT_W-1:0] best_idx;
        logic              out_busy;
    } t_stat;

endpackage

// ----- rtl/priority_aging_task_scheduler.sv -----
// top level of the priority aging task scheduler
// depends on pats_pkg, pats_ctrl, pats_dp
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------
//  request   | i_in_valid / o_in_stall    | mode, task_slot, use_running, prio, exit
//  result    | o_out_valid / i_out_stall  | status, slot, preempt, prio, exit, woken
//  config    | i_cfg_we                   | i_cfg_wdata (quantum_ticks)
//
// pick scans the ready list one entry per cycle, then shifts it one entry per cycle
// join that suspends and exit search the ready list for the running task and drop it;
// exit then runs the wake scan over all 16 slots
// one word is in work at a time; a waiting result holds only the publish of the next word
// synchronous active-low reset, no clearing pass
module priority_aging_task_scheduler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_mode,
    input  logic [3:0]        i_task_slot,
    input  logic              i_use_running,
    input  logic signed [5:0] i_priority_req,
    input  logic signed [7:0] i_exit_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [3:0]        o_slot_out,
    output logic              o_preempt,
    output logic signed [5:0] o_priority_out,
    output logic signed [7:0] o_exit_value_out,
    output logic [3:0]        o_woken_count
);
    import pats_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pats_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_mode),
        .i_task_slot      (i_task_slot),
        .i_use_running    (i_use_running),
        .i_priority_req   (i_priority_req),
        .i_exit_value     (i_exit_value),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_slot_out       (o_slot_out),
        .o_preempt        (o_preempt),
        .o_priority_out   (o_priority_out),
        .o_exit_value_out (o_exit_value_out),
        .o_woken_count    (o_woken_count)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted word did not make the block busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= RES_FULL))
        else $error("result status out of range");

    a_preempt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_preempt) |-> (o_status == RES_OK && o_woken_count == '0))
        else $error("preempt with bad status or woken tasks");

    a_woken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_woken_count != '0) |-> (o_status == RES_OK))
        else $error("woken tasks on a failed request");

endmodule

// ----- rtl/pats_dp.sv -----
// scheduler datapath: task table, ready list, running task, result registers
// depends on pats_pkg
module pats_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pats_pkg::t_cmd          i_cmd,
    output pats_pkg::t_stat         o_stat,
    input  logic                    i_cfg_we,
    input  logic [7:0]              i_cfg_wdata,
    input  logic [2:0]              i_mode,
    input  logic [3:0]              i_task_slot,
    input  logic                    i_use_running,
    input  logic signed [5:0]       i_priority_req,
    input  logic signed [7:0]       i_exit_value,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic [2:0]              o_status,
    output logic [3:0]              o_slot_out,
    output logic                    o_preempt,
    output logic signed [5:0]       o_priority_out,
    output logic signed [7:0]       o_exit_value_out,
    output logic [3:0]              o_woken_count
);
    import pats_pkg::*;

    logic [2:0]              r_state [MAX_TASKS];
    logic signed [5:0]       r_base  [MAX_TASKS];
    logic signed [6:0]       r_aged  [MAX_TASKS];
    logic [SLOT_W-1:0]       r_wait  [MAX_TASKS];
    logic signed [7:0]       r_exit  [MAX_TASKS];
    logic [SLOT_W-1:0]       r_list  [MAX_TASKS];
    logic [LEN_W-1:0]        r_len;
    logic [SLOT_W-1:0]       r_run;
    logic [7:0]              r_ticks;
    logic                    r_disp;
    logic [7:0]              r_quantum;

    logic [2:0]              r_mode;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_use_run;
    logic signed [5:0]       r_prio;
    logic signed [7:0]       r_ev;

    logic [SLOT_W-1:0]       r_best_idx;
    logic [SLOT_W-1:0]       r_best_slot;
    logic signed [6:0]       r_best_val;

    logic [2:0]              r_res_status;
    logic [SLOT_W-1:0]       r_res_slot;
    logic                    r_res_pre;
    logic signed [5:0]       r_res_prio;
    logic signed [7:0]       r_res_exit;
    logic [3:0]              r_woken;

    logic [SLOT_W-1:0]       w_tgt;
    logic [SLOT_W-1:0]       w_list_rd;
    logic signed [6:0]       w_aged_rd;
    logic                    w_better;
    logic [SLOT_W-1:0]       w_free_idx;
    logic                    w_free_any;
    logic                    w_prio_ok;
    logic [2:0]              w_slot_st;
    logic                    w_len_room;
    logic [SLOT_W-1:0]       w_nxt_idx;

    assign w_tgt      = r_use_run ? r_run : r_slot;
    assign w_list_rd  = r_list[i_cmd.idx];
    assign w_aged_rd  = r_aged[w_list_rd];
    assign w_better   = (i_cmd.idx == '0) || (w_aged_rd < r_best_val);
    assign w_prio_ok  = (r_prio >= PRIO_MIN) && (r_prio <= PRIO_MAX);
    assign w_slot_st  = r_state[r_slot];
    assign w_len_room = (r_len < LEN_W'(MAX_TASKS));
    assign w_nxt_idx  = i_cmd.idx + SLOT_W'(1);

    always_comb begin
        w_free_idx = '0;
        w_free_any = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (r_state[i] == ST_FREE) begin
                w_free_idx = SLOT_W'(i);
                w_free_any = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.path = PATH_SIMPLE;
        case (r_mode)
            MODE_PICK: if (r_disp && r_len != '0) o_stat.path = PATH_PICK;
            MODE_EXIT: if (!r_disp) o_stat.path = PATH_EXIT;
            MODE_JOIN: begin
                if (!r_disp && r_slot != r_run && w_slot_st != ST_FREE &&
                    w_slot_st != ST_TERMINATED) o_stat.path = PATH_JOIN;
            end
            default: o_stat.path = PATH_SIMPLE;
        endcase
        o_stat.len      = r_len;
        o_stat.match    = (LEN_W'(i_cmd.idx) < r_len) && (w_list_rd == r_run);
        o_stat.best_idx = (i_cmd.op == OP_PSCAN && w_better) ? i_cmd.idx : r_best_idx;
        o_stat.out_busy = o_out_valid && i_out_stall;
    end

    // task table and scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_state[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
                r_base[i]  <= '0;
                r_aged[i]  <= '0;
                r_list[i]  <= '0;
            end
            r_len     <= LEN_W'(1);
            r_run     <= '0;
            r_ticks   <= QUANTUM_RST;
            r_disp    <= 1'b0;
            r_quantum <= QUANTUM_RST;
        end else begin
            if (i_cfg_we) r_quantum <= i_cfg_wdata;
            case (i_cmd.op)
                OP_SIMPLE: begin
                    case (r_mode)
                        MODE_TICK: begin
                            if (!r_disp) begin
                                if (r_ticks <= 8'd1) begin
                                    r_ticks        <= '0;
                                    r_state[r_run] <= ST_READY;
                                    r_disp         <= 1'b1;
                                end else begin
                                    r_ticks <= r_ticks - 8'd1;
                                end
                            end
                        end
                        MODE_CREATE: begin
                            if (w_free_any) begin
                                r_state[w_free_idx] <= ST_READY;
                                r_base[w_free_idx]  <= '0;
                                r_aged[w_free_idx]  <= '0;
                                if (w_len_room) begin
                                    r_list[r_len[SLOT_W-1:0]] <= w_free_idx;
                                    r_len <= r_len + LEN_W'(1);
                                end
                            end
                        end
                        MODE_SETP: begin
                            if (!(r_use_run && r_disp) && w_prio_ok) r_base[w_tgt] <= r_prio;
                        end
                        MODE_YIELD: begin
                            if (!r_disp) begin
                                r_state[r_run] <= ST_READY;
                                r_disp         <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_PSCAN: begin
                    if (w_aged_rd > AGE_FLOOR) r_aged[w_list_rd] <= w_aged_rd - 7'sd1;
                end
                OP_SHIFT: r_list[i_cmd.idx] <= r_list[w_nxt_idx];
                OP_DROP:  r_len <= r_len - LEN_W'(1);
                OP_WAKE: begin
                    if (r_state[i_cmd.idx] == ST_SUSPENDED && r_wait[i_cmd.idx] == r_run) begin
                        r_state[i_cmd.idx] <= ST_READY;
                        if (w_len_room) begin
                            r_list[r_len[SLOT_W-1:0]] <= i_cmd.idx;
                            r_len <= r_len + LEN_W'(1);
                        end
                    end
                end
                OP_PFIN: begin
                    r_aged[r_best_slot]  <= {r_base[r_best_slot][5], r_base[r_best_slot]};
                    r_list[SLOT_W'(r_len - LEN_W'(1))] <= r_best_slot;
                    r_state[r_best_slot] <= ST_RUNNING;
                    r_run                <= r_best_slot;
                    r_ticks              <= r_quantum;
                    r_disp               <= 1'b0;
                end
                OP_XFIN: begin
                    r_state[r_run] <= ST_TERMINATED;
                    r_disp         <= 1'b1;
                end
                OP_JFIN: begin
                    r_state[r_run] <= ST_SUSPENDED;
                    r_disp         <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // stores without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_XFIN) r_exit[r_run] <= r_ev;
        if (i_cmd.op == OP_JFIN) r_wait[r_run] <= r_slot;
    end

    // latched word, scan registers and working result
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode       <= i_mode;
                r_slot       <= i_task_slot;
                r_use_run    <= i_use_running;
                r_prio       <= i_priority_req;
                r_ev         <= i_exit_value;
                r_res_status <= RES_OK;
                r_res_slot   <= r_run;
                r_res_pre    <= 1'b0;
                r_res_prio   <= '0;
                r_res_exit   <= '0;
                r_woken      <= '0;
            end
            OP_SIMPLE: begin
                case (r_mode)
                    MODE_TICK: begin
                        if (!r_disp && r_ticks <= 8'd1) r_res_pre <= 1'b1;
                    end
                    MODE_CREATE: begin
                        if (w_free_any) r_res_slot <= w_free_idx;
                        else r_res_status <= RES_FULL;
                    end
                    MODE_SETP: begin
                        if ((r_use_run && r_disp) || !w_prio_ok) r_res_status <= RES_REJECT;
                    end
                    MODE_GETP: begin
                        if (r_use_run && r_disp) r_res_status <= RES_REJECT;
                        else r_res_prio <= r_base[w_tgt];
                    end
                    MODE_YIELD, MODE_EXIT: begin
                        if (r_disp) r_res_status <= RES_REJECT;
                    end
                    MODE_PICK: begin
                        r_res_status <= r_disp ? RES_NONE : RES_REJECT;
                    end
                    MODE_JOIN: begin
                        if (w_slot_st == ST_TERMINATED && !r_disp && r_slot != r_run)
                            r_res_exit <= r_exit[r_slot];
                        else r_res_status <= RES_REJECT;
                    end
                    default: ;
                endcase
            end
            OP_PSCAN: begin
                if (w_better) begin
                    r_best_idx  <= i_cmd.idx;
                    r_best_slot <= w_list_rd;
                    r_best_val  <= w_aged_rd;
                end
            end
            OP_WAKE: begin
                if (r_state[i_cmd.idx] == ST_SUSPENDED && r_wait[i_cmd.idx] == r_run)
                    r_woken <= r_woken + 4'd1;
            end
            OP_PFIN: r_res_slot <= r_best_slot;
            OP_JFIN: r_res_status <= RES_SUSPEND;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_PUBLISH) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PUBLISH) begin
            o_status         <= r_res_status;
            o_slot_out       <= r_res_slot;
            o_preempt        <= r_res_pre;
            o_priority_out   <= r_res_prio;
            o_exit_value_out <= r_res_exit;
            o_woken_count    <= r_woken;
        end
    end

endmodule

// ----- rtl/pats_ctrl.sv -----
// scheduler controller: sequences scans, list shifts and wakeups
// depends on pats_pkg
module pats_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  pats_pkg::t_stat i_stat,
    output pats_pkg::t_cmd  o_cmd
);
    import pats_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_PSCAN, S_FIND, S_SHIFT, S_WAKE, S_FIN, S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_path             r_path, n_path;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0]  w_idx_inc;

    assign w_idx_inc  = LEN_W'(r_idx) + LEN_W'(1);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_path    = r_path;
        n_idx     = r_idx;
        o_cmd.op  = OP_NONE;
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_path = i_stat.path;
                n_idx  = '0;
                case (i_stat.path)
                    PATH_SIMPLE: begin
                        o_cmd.op = OP_SIMPLE;
                        n_state  = S_DONE;
                    end
                    PATH_PICK: n_state = S_PSCAN;
                    default:   n_state = S_FIND;
                endcase
            end
            S_PSCAN: begin
                o_cmd.op = OP_PSCAN;
                if (w_idx_inc >= i_stat.len) begin
                    n_idx   = i_stat.best_idx;
                    n_state = S_SHIFT;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_FIND: begin
                o_cmd.op = OP_FIND;
                if (i_stat.match) begin
                    n_state = S_SHIFT;
                end else if (w_idx_inc >= i_stat.len) begin
                    n_idx   = '0;
                    n_state = (r_path == PATH_EXIT) ? S_WAKE : S_FIN;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_SHIFT: begin
                if (w_idx_inc < i_stat.len) begin
                    o_cmd.op = OP_SHIFT;
                    n_idx    = r_idx + SLOT_W'(1);
                end else if (r_path == PATH_PICK) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_DROP;
                    n_idx    = '0;
                    n_state  = (r_path == PATH_EXIT) ? S_WAKE : S_FIN;
                end
            end
            S_WAKE: begin
                o_cmd.op = OP_WAKE;
                if (r_idx == SLOT_W'(MAX_TASKS - 1)) n_state = S_FIN;
                else n_idx = r_idx + SLOT_W'(1);
            end
            S_FIN: begin
                case (r_path)
                    PATH_PICK: o_cmd.op = OP_PFIN;
                    PATH_EXIT: o_cmd.op = OP_XFIN;
                    default:   o_cmd.op = OP_JFIN;
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_path  <= PATH_SIMPLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_path  <= n_path;
            r_idx   <= n_idx;
        end
    end

endmodule
